/* rtl/ptb_pkg.sv */
// Shared types and constants for the piece-table text buffer.
// Standalone package; used by piece_table_text_buffer.
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

    localparam int SPAN_SLOTS     = 64;
    localparam int ORIGINAL_DEPTH = 4096;
    localparam int ADD_DEPTH      = 4096;

    localparam int POS_W = 14;
    localparam int CH_W  = 16;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    localparam int OAW = $clog2(ORIGINAL_DEPTH);
    localparam int AAW = $clog2(ADD_DEPTH);
    localparam int SW  = (OAW > AAW) ? OAW : AAW;   // span start width
    localparam int LW  = SW + 1;                    // span length width
    localparam int OFW = OAW + 1;                   // original fill width
    localparam int AFW = AAW + 1;                   // add fill width
    localparam int SIW = $clog2(SPAN_SLOTS);        // span index width
    localparam int CW  = $clog2(SPAN_SLOTS + 1);    // span count width

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_STORE_FULL = 2'd2;

    localparam logic KIND_ORIG = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] span_length;
        logic [CH_W-1:0]  character;
    } ptb_req_t;

    typedef struct packed {
        logic [CH_W-1:0]  read_char;
        logic             read_valid;
        logic [POS_W-1:0] doc_length;
        logic [ST_W-1:0]  status;
    } ptb_rsp_t;

    typedef struct packed {
        logic          kind;
        logic [SW-1:0] start;
        logic [LW-1:0] len;
    } span_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_PROC,
        S_TAIL,
        S_COMMIT,
        S_RDCH,
        S_FINISH
    } ptb_state_t;

endpackage

`default_nettype wire

/* rtl/piece_table_text_buffer.sv */
// Piece-table text buffer: span table memory (two banks) plus two character stores.
// Depends on ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low. Its result appears on
// result for the single cycle in which done is high and must be captured then.
// Every edit (load, insert, remove) streams the current span table out of one
// bank of the span memory and writes the edited, merged table into the other
// bank, one span per visit. Each extra span piece made by a split or a boundary
// insert takes its own step in the walk; an edit makes at most two such pieces.
// A read walks the same way until it reaches the span that holds the position,
// then reads the character store. Clear, store-full items, unknown codes, removes
// that change nothing and reads outside the document skip the walk and go
// straight to the result. busy drops in the cycle that shows the result, so the
// next item can be accepted then. There is no clearing pass after reset.
module piece_table_text_buffer
    import ptb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ptb_req_t request,
    output logic          busy,
    output logic          done,
    output ptb_rsp_t      result
);

    localparam int SPAN_MEM_DEPTH = 2 ** (SIW + 1);
    localparam int OCW = CW + 1;

    ptb_state_t state_reg, state_next;

    logic             bank_reg, bank_next;
    logic [CW-1:0]    span_count_reg, span_count_next;
    logic [OFW-1:0]   orig_fill_reg, orig_fill_next;
    logic [AFW-1:0]   add_fill_reg, add_fill_next;
    logic [POS_W-1:0] doc_reg, doc_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [ST_W-1:0]  status_reg, status_next;

    logic [CW-1:0]    idx_reg, idx_next;
    logic [POS_W-1:0] cur_reg, cur_next;
    logic [1:0]       phase_reg, phase_next;
    logic             hit_reg, hit_next;
    logic [OCW-1:0]   out_cnt_reg, out_cnt_next;
    span_t            pend_reg, pend_next;
    logic             pend_v_reg, pend_v_next;

    logic [LW-1:0]    ch_addr_reg, ch_addr_next;
    logic             ch_kind_reg, ch_kind_next;
    logic             rvalid_reg, rvalid_next;

    logic             done_reg, done_next;
    ptb_rsp_t         result_reg, result_next;

    // memories
    span_t            span_mem [SPAN_MEM_DEPTH];
    span_t            span_q;
    logic [CH_W-1:0]  orig_mem [ORIGINAL_DEPTH];
    logic [CH_W-1:0]  add_mem  [ADD_DEPTH];
    logic [CH_W-1:0]  orig_q, add_q;

    logic             wr_en;
    logic [SIW:0]     wr_addr;
    span_t            wr_data;
    logic             ow_en, aw_en;

    // item decode
    logic             acc;
    logic [POS_W-1:0] pos_c;
    logic [POS_W:0]   end_sum;
    logic [POS_W-1:0] end_c;
    logic             rem_empty, ofull, afull, rd_in, go_walk;

    assign acc     = start && !busy;
    assign pos_c   = (request.position > doc_reg) ? doc_reg : request.position;
    assign end_sum = {1'b0, pos_c} + {1'b0, request.span_length};
    assign end_c   = (end_sum > {1'b0, doc_reg}) ? doc_reg : end_sum[POS_W-1:0];
    assign rem_empty = (request.span_length == '0) || (doc_reg == '0) || (end_c <= pos_c);
    assign ofull   = (orig_fill_reg == OFW'(ORIGINAL_DEPTH));
    assign afull   = (add_fill_reg == AFW'(ADD_DEPTH));
    assign rd_in   = (request.position < doc_reg) && (span_count_reg != '0);
    assign go_walk = ((request.operation == OP_LOAD) && !ofull)
                  || ((request.operation == OP_INSERT) && !afull)
                  || ((request.operation == OP_REMOVE) && !rem_empty)
                  || ((request.operation == OP_READ) && rd_in);

    // current span geometry
    logic [POS_W-1:0] cend, off, roff;
    span_t            s_new;
    span_t            pc [3];
    logic [1:0]       pc_n;
    logic             pc_hit, last_piece, found, need_tail;
    logic [LW-1:0]    rd_a;
    logic [OCW-1:0]   total;

    assign cend  = cur_reg + POS_W'(span_q.len);
    assign off   = pos_reg - cur_reg;
    assign roff  = (end_reg > cur_reg) ? (end_reg - cur_reg) : '0;
    assign found = (pos_reg >= cur_reg) && (pos_reg < cend);
    assign rd_a  = LW'(span_q.start) + LW'(off);
    assign total = out_cnt_reg + OCW'(pend_v_reg);
    assign need_tail = (op_reg == OP_LOAD) || ((op_reg == OP_INSERT) && !hit_reg);
    assign last_piece = (pc_n == 2'd0) || (phase_reg == (pc_n - 2'd1));

    always_comb
    begin
        if (op_reg == OP_LOAD)
        begin
            s_new = '{kind: KIND_ORIG, start: SW'(orig_fill_reg), len: LW'(1)};
        end
        else
        begin
            s_new = '{kind: KIND_ADD, start: SW'(add_fill_reg), len: LW'(1)};
        end
    end

    // pieces produced from the span under visit
    always_comb
    begin
        pc[0]  = span_q;
        pc[1]  = span_q;
        pc[2]  = span_q;
        pc_n   = 2'd1;
        pc_hit = 1'b0;
        if (op_reg == OP_INSERT && !hit_reg && cend >= pos_reg)
        begin
            pc_hit = 1'b1;
            if (pos_reg == cur_reg)
            begin
                pc[0] = s_new;
                pc_n  = 2'd2;
            end
            else if (pos_reg == cend)
            begin
                pc[1] = s_new;
                pc_n  = 2'd2;
            end
            else
            begin
                pc[0].len   = LW'(off);
                pc[1]       = s_new;
                pc[2].start = span_q.start + SW'(off);
                pc[2].len   = span_q.len - LW'(off);
                pc_n        = 2'd3;
            end
        end
        else if (op_reg == OP_REMOVE)
        begin
            pc_n = 2'd0;
            if (pos_reg > cur_reg)
            begin
                pc[0].len = (pos_reg >= cend) ? span_q.len : LW'(off);
                pc_n      = 2'd1;
            end
            if (end_reg < cend)
            begin
                pc[pc_n].start = span_q.start + SW'(roff);
                pc[pc_n].len   = span_q.len - LW'(roff);
                pc_n           = pc_n + 2'd1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    state_next = go_walk ? S_FETCH : S_FINISH;
                end
            end
            S_FETCH:
            begin
                if (idx_reg == span_count_reg)
                begin
                    state_next = (op_reg == OP_READ) ? S_FINISH : S_TAIL;
                end
                else
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (op_reg == OP_READ)
                begin
                    state_next = found ? S_RDCH : S_FETCH;
                end
                else if (last_piece)
                begin
                    state_next = S_FETCH;
                end
            end
            S_TAIL:   state_next = S_COMMIT;
            S_COMMIT: state_next = S_FINISH;
            S_RDCH:   state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    logic          emit_v;
    span_t         emit_s;
    logic [LW:0]   pend_end;
    logic          join_ok;

    assign pend_end = (LW + 1)'(pend_reg.start) + (LW + 1)'(pend_reg.len);

    always_comb
    begin
        bank_next       = bank_reg;
        span_count_next = span_count_reg;
        orig_fill_next  = orig_fill_reg;
        add_fill_next   = add_fill_reg;
        doc_next        = doc_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        ch_next         = ch_reg;
        status_next     = status_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        phase_next      = phase_reg;
        hit_next        = hit_reg;
        out_cnt_next    = out_cnt_reg;
        pend_next       = pend_reg;
        pend_v_next     = pend_v_reg;
        ch_addr_next    = ch_addr_reg;
        ch_kind_next    = ch_kind_reg;
        rvalid_next     = rvalid_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        wr_en           = 1'b0;
        wr_addr         = {~bank_reg, out_cnt_reg[SIW-1:0]};
        wr_data         = pend_reg;
        ow_en           = 1'b0;
        aw_en           = 1'b0;
        emit_v          = 1'b0;
        emit_s          = s_new;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    op_next      = request.operation;
                    pos_next     = pos_c;
                    end_next     = end_c;
                    ch_next      = request.character;
                    status_next  = ST_OK;
                    idx_next     = '0;
                    cur_next     = '0;
                    phase_next   = '0;
                    hit_next     = 1'b0;
                    out_cnt_next = '0;
                    pend_v_next  = 1'b0;
                    rvalid_next  = 1'b0;
                    if (request.operation == OP_CLEAR)
                    begin
                        span_count_next = '0;
                        orig_fill_next  = '0;
                        add_fill_next   = '0;
                        doc_next        = '0;
                    end
                    else if ((request.operation == OP_LOAD && ofull)
                          || (request.operation == OP_INSERT && afull))
                    begin
                        status_next = ST_STORE_FULL;
                    end
                end
            end
            S_FETCH: ;
            S_PROC:
            begin
                if (op_reg == OP_READ)
                begin
                    if (found)
                    begin
                        ch_addr_next = rd_a;
                        ch_kind_next = span_q.kind;
                        rvalid_next  = span_q.kind ? (rd_a < LW'(add_fill_reg))
                                                   : (rd_a < LW'(orig_fill_reg));
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        cur_next = cend;
                    end
                end
                else
                begin
                    emit_v = (pc_n != 2'd0);
                    emit_s = pc[phase_reg];
                    if (last_piece)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        cur_next   = cend;
                        phase_next = '0;
                        hit_next   = hit_reg | pc_hit;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            S_TAIL:
            begin
                emit_v = need_tail;
                emit_s = s_new;
            end
            S_COMMIT:
            begin
                // flush the last pending span, then swap banks if it fits
                wr_en = pend_v_reg && (out_cnt_reg < OCW'(SPAN_SLOTS));
                if (total > OCW'(SPAN_SLOTS))
                begin
                    status_next = ST_TABLE_FULL;
                end
                else
                begin
                    bank_next       = ~bank_reg;
                    span_count_next = CW'(total);
                    if (op_reg == OP_LOAD)
                    begin
                        ow_en          = 1'b1;
                        orig_fill_next = orig_fill_reg + 1'b1;
                        doc_next       = doc_reg + 1'b1;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        aw_en         = 1'b1;
                        add_fill_next = add_fill_reg + 1'b1;
                        doc_next      = doc_reg + 1'b1;
                    end
                    else
                    begin
                        doc_next = doc_reg - (end_reg - pos_reg);
                    end
                end
            end
            S_RDCH: ;
            S_FINISH:
            begin
                done_next              = 1'b1;
                result_next.read_valid = rvalid_reg;
                result_next.read_char  = !rvalid_reg ? '0 : (ch_kind_reg ? add_q : orig_q);
                result_next.doc_length = doc_reg;
                result_next.status     = status_reg;
            end
            default: ;
        endcase

        join_ok = pend_v_reg && (pend_reg.kind == emit_s.kind)
               && (pend_end == (LW + 1)'(emit_s.start));

        // merge-on-write: extend the pending span or retire it to the new bank
        if (emit_v)
        begin
            if (join_ok)
            begin
                pend_next.len = pend_reg.len + emit_s.len;
            end
            else
            begin
                if (pend_v_reg)
                begin
                    wr_en        = (out_cnt_reg < OCW'(SPAN_SLOTS));
                    out_cnt_next = out_cnt_reg + 1'b1;
                end
                pend_next   = emit_s;
                pend_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bank_reg       <= 1'b0;
            span_count_reg <= '0;
            orig_fill_reg  <= '0;
            add_fill_reg   <= '0;
            doc_reg        <= '0;
            done_reg       <= 1'b0;
            pend_v_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            phase_reg      <= '0;
            idx_reg        <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            span_count_reg <= span_count_next;
            orig_fill_reg  <= orig_fill_next;
            add_fill_reg   <= add_fill_next;
            doc_reg        <= doc_next;
            done_reg       <= done_next;
            pend_v_reg     <= pend_v_next;
            hit_reg        <= hit_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        end_reg     <= end_next;
        ch_reg      <= ch_next;
        status_reg  <= status_next;
        cur_reg     <= cur_next;
        pend_reg    <= pend_next;
        ch_addr_reg <= ch_addr_next;
        ch_kind_reg <= ch_kind_next;
        rvalid_reg  <= rvalid_next;
        result_reg  <= result_next;
    end

    // span table memory, one bank read while the other is written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            span_mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_FETCH)
        begin
            span_q <= span_mem[{bank_reg, idx_reg[SIW-1:0]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ow_en)
        begin
            orig_mem[orig_fill_reg[OAW-1:0]] <= ch_reg;
        end
        orig_q <= orig_mem[ch_addr_reg[OAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (aw_en)
        begin
            add_mem[add_fill_reg[AAW-1:0]] <= ch_reg;
        end
        add_q <= add_mem[ch_addr_reg[AAW-1:0]];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        span_count_reg <= CW'(SPAN_SLOTS))
        else $error("span count above table size");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (orig_fill_reg <= OFW'(ORIGINAL_DEPTH)) && (add_fill_reg <= AFW'(ADD_DEPTH)))
        else $error("store fill above depth");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.read_valid) |-> (result.status == ST_OK))
        else $error("valid read with error status");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire
